// File: rtl/plle_pkg.sv
// Shared constants, codes and types of the pooled linked list engine.
package plle_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
  localparam int OP_W       = 2;
  localparam int NODE_W     = 4;
  localparam int USED_W     = 5;
  localparam int IDXX_W     = (LINK_W > NODE_W) ? LINK_W : NODE_W;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_ADD          = 2'd0,
    OP_REMOVE_FIRST = 2'd1,
    OP_REMOVE_NODE  = 2'd2,
    OP_CLEAN        = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_CHECK,
    ST_ADD_POP,
    ST_ADD_LINK,
    ST_ADD_COMMIT,
    ST_RF_CHECK,
    ST_RF_WALK,
    ST_RN_CHECK,
    ST_CL_LOOP,
    ST_FREE_READ,
    ST_FREE_UNLINK,
    ST_FREE_PUSH,
    ST_DONE
  } state_e;

  // read addresses into the link store
  typedef struct packed {
    logic [IDX_W-1:0] nxt_addr;
    logic [IDX_W-1:0] prv_addr;
    logic [IDX_W-1:0] flg_addr;
  } rd_req_t;

  typedef struct packed {
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
    logic              flg;
  } rd_rsp_t;

  // one write per array per cycle
  typedef struct packed {
    logic              nxt_we;
    logic [IDX_W-1:0]  nxt_addr;
    logic [LINK_W-1:0] nxt_data;
    logic              prv_we;
    logic [IDX_W-1:0]  prv_addr;
    logic [LINK_W-1:0] prv_data;
    logic              flg_we;
    logic [IDX_W-1:0]  flg_addr;
    logic              flg_data;
  } wr_req_t;

  typedef struct packed {
    logic              valid;
    logic              status;
    logic [LINK_W-1:0] node;
    logic [LINK_W-1:0] count;
  } result_t;

endpackage

// File: rtl/plle_links.sv
// Link store: next links, prev links and in-use flags of the node pool.
module plle_links (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  plle_pkg::rd_req_t rd_i,
  output plle_pkg::rd_rsp_t rd_o,
  input  plle_pkg::wr_req_t wr_i
);
  import plle_pkg::*;

  logic [LINK_W-1:0]     nxt_q [POOL_DEPTH];
  logic [LINK_W-1:0]     prv_q [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] flg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        nxt_q[i] <= (i + 1 < POOL_DEPTH) ? LINK_W'(i + 1) : NIL_LINK;
        prv_q[i] <= (i == 0) ? NIL_LINK : LINK_W'(i - 1);
      end
      flg_q <= '0;
    end else begin
      if (wr_i.nxt_we) nxt_q[wr_i.nxt_addr] <= wr_i.nxt_data;
      if (wr_i.prv_we) prv_q[wr_i.prv_addr] <= wr_i.prv_data;
      if (wr_i.flg_we) flg_q[wr_i.flg_addr] <= wr_i.flg_data;
    end
  end

  assign rd_o.nxt = nxt_q[rd_i.nxt_addr];
  assign rd_o.prv = prv_q[rd_i.prv_addr];
  assign rd_o.flg = flg_q[rd_i.flg_addr];

endmodule

// File: rtl/plle_seq.sv
// Operation sequencer: list heads, counters and the step-by-step link walk.
module plle_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [plle_pkg::OP_W-1:0]   operation_i,
  input  logic [plle_pkg::NODE_W-1:0] node_index_i,
  output logic                       busy_o,
  input  logic                       out_free_i,
  output plle_pkg::result_t           result_o,
  output plle_pkg::rd_req_t           rd_o,
  input  plle_pkg::rd_rsp_t           rd_i,
  output plle_pkg::wr_req_t           wr_o
);
  import plle_pkg::*;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [NODE_W-1:0]  idx_q, idx_d;
  logic [LINK_W-1:0]  tail_q, tail_d;
  logic [LINK_W-1:0]  ftop_q, ftop_d;
  logic [LINK_W-1:0]  count_q, count_d;
  logic [LINK_W-1:0]  cur_q, cur_d;
  logic [LINK_W-1:0]  p_q, p_d;
  logic [LINK_W-1:0]  q_q, q_d;
  logic [LINK_W-1:0]  steps_q, steps_d;
  logic               res_status_q, res_status_d;
  logic [LINK_W-1:0]  res_node_q, res_node_d;

  logic [IDXX_W-1:0]  idx_ext;
  logic               add_ok, rf_ok, rn_ok, walk_more, clean_more;

  assign idx_ext    = IDXX_W'(idx_q);
  assign add_ok     = (count_q < NIL_LINK) && (ftop_q < NIL_LINK);
  assign rf_ok      = (count_q != '0) && (tail_q < NIL_LINK);
  assign rn_ok      = (idx_ext < IDXX_W'(POOL_DEPTH)) && rd_i.flg && (count_q != '0);
  assign walk_more  = (rd_i.prv < NIL_LINK) && (steps_q < NIL_LINK);
  assign clean_more = (tail_q < NIL_LINK) && (steps_q < NIL_LINK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tail_q  <= NIL_LINK;
      ftop_q  <= LINK_W'(POOL_DEPTH - 1);
      count_q <= '0;
    end else begin
      state_q <= state_d;
      tail_q  <= tail_d;
      ftop_q  <= ftop_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    idx_q        <= idx_d;
    cur_q        <= cur_d;
    p_q          <= p_d;
    q_q          <= q_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_node_q   <= res_node_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(operation_i))
            OP_ADD:          state_d = ST_ADD_CHECK;
            OP_REMOVE_FIRST: state_d = ST_RF_CHECK;
            OP_REMOVE_NODE:  state_d = ST_RN_CHECK;
            default:         state_d = ST_CL_LOOP;
          endcase
        end
      end
      ST_ADD_CHECK:   state_d = add_ok ? ST_ADD_POP : ST_DONE;
      ST_ADD_POP:     state_d = ST_ADD_LINK;
      ST_ADD_LINK:    state_d = ST_ADD_COMMIT;
      ST_ADD_COMMIT:  state_d = ST_DONE;
      ST_RF_CHECK:    state_d = rf_ok ? ST_RF_WALK : ST_DONE;
      ST_RF_WALK:     state_d = walk_more ? ST_RF_WALK : ST_FREE_READ;
      ST_RN_CHECK:    state_d = rn_ok ? ST_FREE_READ : ST_DONE;
      ST_CL_LOOP:     state_d = clean_more ? ST_FREE_READ : ST_DONE;
      ST_FREE_READ:   state_d = ST_FREE_UNLINK;
      ST_FREE_UNLINK: state_d = ST_FREE_PUSH;
      ST_FREE_PUSH:   state_d = (op_q == OP_CLEAN) ? ST_CL_LOOP : ST_DONE;
      ST_DONE:        state_d = out_free_i ? ST_IDLE : ST_DONE;
      default:        state_d = ST_IDLE;
    endcase
  end

  // datapath and link store control
  always_comb begin
    op_d         = op_q;
    idx_d        = idx_q;
    tail_d       = tail_q;
    ftop_d       = ftop_q;
    count_d      = count_q;
    cur_d        = cur_q;
    p_d          = p_q;
    q_d          = q_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    res_node_d   = res_node_q;
    wr_o         = '0;
    rd_o.nxt_addr = cur_q[IDX_W-1:0];
    rd_o.prv_addr = cur_q[IDX_W-1:0];
    rd_o.flg_addr = idx_ext[IDX_W-1:0];
    result_o.valid  = 1'b0;
    result_o.status = res_status_q;
    result_o.node   = res_node_q;
    result_o.count  = count_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d         = op_e'(operation_i);
          idx_d        = node_index_i;
          steps_d      = '0;
          res_status_d = 1'b1;
          res_node_d   = '0;
        end
      end
      ST_ADD_CHECK: begin
        rd_o.prv_addr = ftop_q[IDX_W-1:0];
        if (add_ok) begin
          cur_d  = ftop_q;
          ftop_d = rd_i.prv;
        end
      end
      ST_ADD_POP: begin
        if (ftop_q < NIL_LINK) begin
          wr_o.nxt_we   = 1'b1;
          wr_o.nxt_addr = ftop_q[IDX_W-1:0];
          wr_o.nxt_data = NIL_LINK;
        end
      end
      ST_ADD_LINK: begin
        if (tail_q < NIL_LINK) begin
          wr_o.nxt_we   = 1'b1;
          wr_o.nxt_addr = tail_q[IDX_W-1:0];
          wr_o.nxt_data = cur_q;
        end
      end
      ST_ADD_COMMIT: begin
        wr_o.prv_we   = 1'b1;
        wr_o.prv_addr = cur_q[IDX_W-1:0];
        wr_o.prv_data = tail_q;
        wr_o.nxt_we   = 1'b1;
        wr_o.nxt_addr = cur_q[IDX_W-1:0];
        wr_o.nxt_data = NIL_LINK;
        wr_o.flg_we   = 1'b1;
        wr_o.flg_addr = cur_q[IDX_W-1:0];
        wr_o.flg_data = 1'b1;
        tail_d        = cur_q;
        count_d       = count_q + LINK_W'(1);
        res_status_d  = 1'b0;
        res_node_d    = cur_q;
      end
      ST_RF_CHECK: begin
        if (rf_ok) begin
          cur_d   = tail_q;
          steps_d = '0;
        end
      end
      ST_RF_WALK: begin
        if (walk_more) begin
          cur_d   = rd_i.prv;
          steps_d = steps_q + LINK_W'(1);
        end
      end
      ST_RN_CHECK: begin
        if (rn_ok) cur_d = LINK_W'(idx_ext);
      end
      ST_CL_LOOP: begin
        if (clean_more) begin
          cur_d   = tail_q;
          steps_d = steps_q + LINK_W'(1);
        end else begin
          res_status_d = 1'b0;
          res_node_d   = '0;
        end
      end
      ST_FREE_READ: begin
        p_d = rd_i.prv;
        q_d = rd_i.nxt;
        if (cur_q == tail_q) tail_d = rd_i.prv;
      end
      ST_FREE_UNLINK: begin
        if (q_q < NIL_LINK) begin
          wr_o.prv_we   = 1'b1;
          wr_o.prv_addr = q_q[IDX_W-1:0];
          wr_o.prv_data = p_q;
        end
        if (p_q < NIL_LINK) begin
          wr_o.nxt_we   = 1'b1;
          wr_o.nxt_addr = p_q[IDX_W-1:0];
          wr_o.nxt_data = q_q;
        end
      end
      ST_FREE_PUSH: begin
        wr_o.prv_we   = 1'b1;
        wr_o.prv_addr = cur_q[IDX_W-1:0];
        wr_o.prv_data = ftop_q;
        wr_o.nxt_we   = 1'b1;
        wr_o.nxt_addr = cur_q[IDX_W-1:0];
        wr_o.nxt_data = NIL_LINK;
        wr_o.flg_we   = 1'b1;
        wr_o.flg_addr = cur_q[IDX_W-1:0];
        wr_o.flg_data = 1'b0;
        ftop_d        = cur_q;
        if (count_q != '0) count_d = count_q - LINK_W'(1);
        if (op_q != OP_CLEAN) begin
          res_status_d = 1'b0;
          res_node_d   = cur_q;
        end
      end
      ST_DONE: begin
        result_o.valid = out_free_i;
      end
      default: begin
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: rtl/pooled_linked_list_engine_core.sv
// Top level of the pooled linked list engine: sequencer, link store, result register.
//
// A pool of POOL_DEPTH node slots is kept as a doubly linked in-use list plus
// a free stack threaded through the prev links; after reset all nodes are
// free, highest index on top. Each input word (operation, node_index) gives
// exactly one result word (status, result_node, used_count). Add last pops the
// top free node and appends it; remove first walks back from the tail to the
// head and frees the head; remove node frees a given in-use node; clean frees
// from the tail until the list is empty and always succeeds. Full, empty,
// out-of-pool and not-in-use requests return status 1, result_node 0 and leave
// the lists alone. One word is worked on at a time: in_stall_o is high from
// acceptance until the result sits in the output register, and a new word may
// be taken while that result still waits. Every link access goes through the
// single read/write port of each link array under the sequencer, so the time
// from one accepted word to the next is set by the link walk, the writes and
// a stalled output register: add last steps through check, pop, link and
// commit; remove first walks one node per step from the tail back to the
// head, then reads, unlinks and pushes it; remove node checks, then reads,
// unlinks and pushes; clean repeats read, unlink and push per freed node.
module pooled_linked_list_engine_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [plle_pkg::OP_W-1:0]   operation_i,
  input  logic [plle_pkg::NODE_W-1:0] node_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       status_o,
  output logic [plle_pkg::NODE_W-1:0] result_node_o,
  output logic [plle_pkg::USED_W-1:0] used_count_o
);
  import plle_pkg::*;

  rd_req_t rd_req;
  rd_rsp_t rd_rsp;
  wr_req_t wr_req;
  result_t result;
  logic    busy;
  logic    out_free;

  // output word register
  logic              out_valid_q;
  logic              status_q;
  logic [NODE_W-1:0] node_q;
  logic [USED_W-1:0] used_q;

  // the output register can take a word when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  plle_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .operation_i  (operation_i),
    .node_index_i (node_index_i),
    .busy_o       (busy),
    .out_free_i   (out_free),
    .result_o     (result),
    .rd_o         (rd_req),
    .rd_i         (rd_rsp),
    .wr_o         (wr_req)
  );

  plle_links u_links (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd_req),
    .rd_o   (rd_rsp),
    .wr_i   (wr_req)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      status_q <= result.status;
      node_q   <= NODE_W'(result.node);
      used_q   <= USED_W'(result.count);
    end
  end

  assign in_stall_o    = busy;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign result_node_o = node_q;
  assign used_count_o  = used_q;

endmodule

// File: sim/tb_pooled_linked_list_engine_core.sv
// Self-checking testbench of the pooled linked list engine: random traffic, predicted results.
module tb_pooled_linked_list_engine_core;
  import plle_pkg::*;

  localparam int RANDOM_WORDS  = 1725;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 100;   // margin for a full clean to finish
  localparam int PAUSE_AT      = 600;   // sender waits for an empty scoreboard here
  localparam int HOLDOFF_AT    = 400;   // receiver holds off once here
  localparam int HOLDOFF_LEN   = 300;
  localparam int QUIET_LO      = 900;   // stretch with no idling on either side
  localparam int QUIET_HI      = 1100;

  typedef struct {
    op_e              op;
    logic [NODE_W-1:0] idx;
  } list_cmd_t;

  typedef struct {
    logic              status;
    logic [NODE_W-1:0] node;
    logic [USED_W-1:0] count;
  } list_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // driven side of the block
  logic              drv_valid = 1'b0;
  logic [OP_W-1:0]   drv_op    = '0;
  logic [NODE_W-1:0] drv_idx   = '0;
  logic              rcv_stall = 1'b0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic              status_o;
  logic [NODE_W-1:0] result_node_o;
  logic [USED_W-1:0] used_count_o;

  list_cmd_t cmd_q[$];      // words still to be offered
  list_rsp_t rsp_q[$];      // results predicted, not yet seen
  int        words_taken  = 0;
  int        results_seen = 0;
  int        hold_left    = 0;
  bit        hold_done    = 1'b0;
  int        errors       = 0;
  int        cycles       = 0;

  // shadow copy of the pool
  logic [LINK_W-1:0] nxt_lnk [POOL_DEPTH];
  logic [LINK_W-1:0] prv_lnk [POOL_DEPTH];
  bit                used_flag [POOL_DEPTH];
  logic [LINK_W-1:0] tail_ptr;
  logic [LINK_W-1:0] free_ptr;
  int                used_cnt;

  pooled_linked_list_engine_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (drv_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (drv_op),
    .node_index_i  (drv_idx),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (rcv_stall),
    .status_o      (status_o),
    .result_node_o (result_node_o),
    .used_count_o  (used_count_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void pool_reset();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      nxt_lnk[i]   = (i + 1 < POOL_DEPTH) ? LINK_W'(i + 1) : NIL_LINK;
      prv_lnk[i]   = (i == 0) ? NIL_LINK : LINK_W'(i - 1);
      used_flag[i] = 1'b0;
    end
    tail_ptr = NIL_LINK;
    free_ptr = LINK_W'(POOL_DEPTH - 1);
    used_cnt = 0;
  endfunction

  // unlink an in-use slot, push it on the free stack
  function automatic void release_slot(logic [LINK_W-1:0] n);
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] q;
    p = prv_lnk[n[IDX_W-1:0]];
    q = nxt_lnk[n[IDX_W-1:0]];
    if (n == tail_ptr) tail_ptr = p;
    if (q < NIL_LINK) prv_lnk[q[IDX_W-1:0]] = p;
    if (p < NIL_LINK) nxt_lnk[p[IDX_W-1:0]] = q;
    prv_lnk[n[IDX_W-1:0]]   = free_ptr;
    nxt_lnk[n[IDX_W-1:0]]   = NIL_LINK;
    free_ptr                = n;
    used_flag[n[IDX_W-1:0]] = 1'b0;
    if (used_cnt > 0) used_cnt--;
  endfunction

  // apply one word to the shadow pool, return what the block must answer
  function automatic list_rsp_t list_apply(list_cmd_t c);
    list_rsp_t         r;
    logic [LINK_W-1:0] n;
    int                steps;
    r.status = 1'b1;
    n        = '0;
    steps    = 0;
    case (c.op)
      OP_ADD: begin
        if (used_cnt < POOL_DEPTH && free_ptr < NIL_LINK) begin
          n        = free_ptr;
          free_ptr = prv_lnk[n[IDX_W-1:0]];
          if (free_ptr < NIL_LINK) nxt_lnk[free_ptr[IDX_W-1:0]] = NIL_LINK;
          if (tail_ptr < NIL_LINK) nxt_lnk[tail_ptr[IDX_W-1:0]] = n;
          prv_lnk[n[IDX_W-1:0]]   = tail_ptr;
          nxt_lnk[n[IDX_W-1:0]]   = NIL_LINK;
          tail_ptr                = n;
          used_flag[n[IDX_W-1:0]] = 1'b1;
          used_cnt++;
          r.status = 1'b0;
        end
      end
      OP_REMOVE_FIRST: begin
        if (used_cnt > 0 && tail_ptr < NIL_LINK) begin
          n = tail_ptr;
          while (prv_lnk[n[IDX_W-1:0]] < NIL_LINK && steps < POOL_DEPTH) begin
            n = prv_lnk[n[IDX_W-1:0]];
            steps++;
          end
          release_slot(n);
          r.status = 1'b0;
        end
      end
      OP_REMOVE_NODE: begin
        if (used_flag[c.idx] && used_cnt > 0) begin
          n = LINK_W'(c.idx);
          release_slot(n);
          r.status = 1'b0;
        end
      end
      default: begin
        // clean succeeds even on an empty list
        while (tail_ptr < NIL_LINK && steps < POOL_DEPTH) begin
          release_slot(tail_ptr);
          steps++;
        end
        r.status = 1'b0;
      end
    endcase
    r.node  = (r.status == 1'b0 && c.op != OP_CLEAN) ? n[NODE_W-1:0] : '0;
    r.count = USED_W'(used_cnt);
    return r;
  endfunction

  function automatic void push_cmd(op_e op, int idx);
    list_cmd_t c;
    c.op  = op;
    c.idx = NODE_W'(idx);
    cmd_q.push_back(c);
  endfunction

  // Driver: a word is taken at an edge with valid high and stall low; the
  // prediction is made right there, so the scoreboard stays in word order.
  // A new word is only put up once the current one is gone, so a stalled
  // payload never moves and valid never looks at stall.
  always @(posedge clk_i) begin
    logic      take;
    logic      offer;
    list_cmd_t c;
    if (rst_ni) begin
      take = drv_valid && !in_stall_o;
      if (take) begin
        c.op  = op_e'(drv_op);
        c.idx = drv_idx;
        rsp_q.push_back(list_apply(c));
        words_taken++;
      end
      if (!drv_valid || take) begin
        offer = cmd_q.size() > 0;
        // one pause until every predicted result is back
        if (words_taken == PAUSE_AT && rsp_q.size() != 0) offer = 1'b0;
        // random gaps, except in the quiet stretch
        if (!(words_taken >= QUIET_LO && words_taken < QUIET_HI) &&
            $urandom_range(99) < 25) offer = 1'b0;
        if (offer) begin
          c = cmd_q.pop_front();
          drv_op    <= c.op;
          drv_idx   <= c.idx;
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once: the sender keeps offering meanwhile, so
  // the output register fills and the block has to stall its input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && results_seen >= HOLDOFF_AT) begin
        hold_left <= HOLDOFF_LEN;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Monitor: compare each taken result word with the oldest prediction.
  always @(posedge clk_i) begin
    list_rsp_t e;
    logic      nstall;
    if (rst_ni) begin
      if (out_valid_o && !rcv_stall) begin
        if (rsp_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = rsp_q.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            errors++;
          end
          if (result_node_o !== e.node) begin
            $error("result_node: expected %0d, got %0d", e.node, result_node_o);
            errors++;
          end
          if (used_count_o !== e.count) begin
            $error("used_count: expected %0d, got %0d", e.count, used_count_o);
            errors++;
          end
        end
        results_seen++;
      end
      if (hold_left > 0 || (!hold_done && results_seen >= HOLDOFF_AT))
        nstall = 1'b1;
      else if (results_seen >= QUIET_LO && results_seen < QUIET_HI)
        nstall = 1'b0;
      else
        nstall = ($urandom_range(99) < 25);
      rcv_stall <= nstall;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int r;
    pool_reset();

    // directed: empty list cases, fill to full and past it, ends of the range
    push_cmd(OP_CLEAN, 0);           // clean on an empty list still succeeds
    push_cmd(OP_REMOVE_FIRST, 0);    // empty list
    push_cmd(OP_REMOVE_NODE, 0);     // slot not in use
    push_cmd(OP_REMOVE_NODE, 15);
    for (int i = 0; i < POOL_DEPTH; i++) push_cmd(OP_ADD, i);
    push_cmd(OP_ADD, 15);            // pool full
    push_cmd(OP_REMOVE_NODE, 0);     // tail
    push_cmd(OP_REMOVE_NODE, 15);    // head
    push_cmd(OP_REMOVE_FIRST, 0);
    push_cmd(OP_CLEAN, 15);

    // random mix, weighted toward add and remove node so the pool churns
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      r = $urandom_range(99);
      if (r < 45)      push_cmd(OP_ADD, $urandom_range(15));
      else if (r < 65) push_cmd(OP_REMOVE_FIRST, $urandom_range(15));
      else if (r < 95) push_cmd(OP_REMOVE_NODE, $urandom_range(15));
      else             push_cmd(OP_CLEAN, $urandom_range(15));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all words taken, all predictions matched, then a latency's worth
    @(negedge clk_i);
    while (cmd_q.size() != 0 || drv_valid || rsp_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
